### src/rsffa_pkg.sv
package rsffa_pkg;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_OVER   = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_SCAN,
        B_MARK_RD,
        B_MARK_WR,
        B_DONE
    } t_back_state;

    localparam int WORD_BITS         = 32;
    localparam int WORD_LSB          = 5;
    localparam int HEADER_BYTES      = 5;
    localparam int SECTOR_BYTES      = 4096;
    localparam int SECTOR_SHIFT      = 12;
    localparam int COUNT_LIMIT       = 255;
    localparam int FIRST_DATA_SECTOR = 2;
    localparam int SECTOR_ROUND      = HEADER_BYTES + SECTOR_BYTES - 1;

    // One queued job: everything the scanner needs about one transaction.
    typedef struct packed {
        t_status            status;
        logic signed [16:0] region_x;
        logic signed [16:0] region_z;
        logic [9:0]         entry_index;
        logic [7:0]         need;
    } t_job;

endpackage

### src/rsffa_if.sv
interface rsffa_req_if;
    logic               valid;
    logic               ready;
    logic signed [21:0] chunk_x;
    logic signed [21:0] chunk_z;
    logic [23:0]        compressed_bytes;

    modport source (output valid, output chunk_x, output chunk_z,
                    output compressed_bytes, input ready);
    modport sink   (input valid, input chunk_x, input chunk_z,
                    input compressed_bytes, output ready);
endinterface

interface rsffa_rsp_if;
    logic                valid;
    logic                ready;
    rsffa_pkg::t_status  status;
    logic signed [16:0]  region_x;
    logic signed [16:0]  region_z;
    logic [9:0]          entry_index;
    logic [11:0]         sector_offset;
    logic [7:0]          sector_count;
    logic [31:0]         location_word;

    modport source (output valid, output status, output region_x, output region_z,
                    output entry_index, output sector_offset, output sector_count,
                    output location_word, input ready);
    modport sink   (input valid, input status, input region_x, input region_z,
                    input entry_index, input sector_offset, input sector_count,
                    input location_word, output ready);
endinterface

### src/region_sector_first_fit_allocator_unit.sv
// First-fit sector allocator for one region of a chunk store.
// i_req carries a chunk coordinate pair and the compressed payload length;
// o_rsp returns the region, the header slot, the status and, when placed,
// the sector offset, the sector count and the packed location word.
// Both channels move a transaction when valid and ready are high together.
// The front end classifies each request in the cycle it is accepted and
// parks it in a two-entry queue, so while the queue has room it keeps taking
// requests while the scanner is busy or a result waits in the output register.
// The scanner reads the sector bitmap one 32-sector word per cycle. A placed
// request scans the words up to the one holding the end of the run, then reads
// and writes back each word the run touches (at most 9); a full store costs a
// scan of all MAX_SECTORS/32 words. Empty and oversized payloads skip the scan.
// After reset the scanner clears all MAX_SECTORS/32 bitmap words (rounded up) and
// takes no request meanwhile; sectors 0 and 1 stay reserved.
// When the receiver stalls, the result is held and the scanner waits with the
// next finished result; the queue still fills from i_req.
module region_sector_first_fit_allocator_unit #(
    parameter int MAX_SECTORS = 4096
) (
    input logic         i_clk,
    input logic         i_rst_n,
    rsffa_req_if.sink   i_req,
    rsffa_rsp_if.source o_rsp
);

    rsffa_pkg::t_job w_job;
    logic            w_job_valid;
    logic            w_job_ready;

    rsffa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_ready (w_job_ready)
    );

    rsffa_back #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_ready (w_job_ready),
        .o_rsp       (o_rsp)
    );

endmodule

### src/rsffa_front.sv
module rsffa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rsffa_req_if.sink         i_req,
    output rsffa_pkg::t_job   o_job,
    output logic              o_job_valid,
    input  logic              i_job_ready
);

    localparam int DEPTH = 2;

    logic [24:0]     w_padded;
    logic [12:0]     w_need;
    rsffa_pkg::t_job w_job;
    logic            w_push;
    logic            w_pop;

    rsffa_pkg::t_job r_queue [DEPTH];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;

    // Payload plus header bytes, rounded up to whole sectors.
    assign w_padded = 25'(i_req.compressed_bytes) + 25'(rsffa_pkg::SECTOR_ROUND);
    assign w_need   = w_padded[24:rsffa_pkg::SECTOR_SHIFT];

    always_comb begin
        w_job.region_x    = $signed(i_req.chunk_x[21:5]);
        w_job.region_z    = $signed(i_req.chunk_z[21:5]);
        w_job.entry_index = {i_req.chunk_z[4:0], i_req.chunk_x[4:0]};
        w_job.need        = w_need[7:0];
        priority if (i_req.compressed_bytes == '0) begin
            w_job.status = rsffa_pkg::ST_EMPTY;
        end else if (w_need > 13'(rsffa_pkg::COUNT_LIMIT)) begin
            w_job.status = rsffa_pkg::ST_OVER;
        end else begin
            w_job.status = rsffa_pkg::ST_PLACED;
        end
    end

    assign i_req.ready = (r_count != 2'(DEPTH));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_job_valid = (r_count != '0);
    assign w_pop       = o_job_valid && i_job_ready;
    assign o_job       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_job;
        end
    end

endmodule

### src/rsffa_back.sv
module rsffa_back #(
    parameter int MAX_SECTORS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsffa_pkg::t_job   i_job,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    rsffa_rsp_if.source       o_rsp
);

    localparam int WB        = rsffa_pkg::WORD_BITS;
    localparam int NW        = (MAX_SECTORS + WB - 1) / WB;
    localparam int AW        = (NW > 1) ? $clog2(NW) : 1;
    localparam int SW        = AW + rsffa_pkg::WORD_LSB;
    localparam int TAIL_BITS = MAX_SECTORS - (NW - 1) * WB;
    localparam logic [WB-1:0] TAIL_MASK =
        WB'(~((64'd1 << TAIL_BITS) - 64'd1));
    localparam logic [WB-1:0] RESERVED_MASK =
        WB'((64'd1 << rsffa_pkg::FIRST_DATA_SECTOR) - 64'd1);
    localparam logic [AW-1:0] LAST_WORD = AW'(NW - 1);

    // Sector-used bitmap, one word per row.
    logic [WB-1:0] r_bitmap [NW];
    logic [WB-1:0] r_rdata;

    logic          w_mem_we;
    logic [AW-1:0] w_mem_waddr;
    logic [WB-1:0] w_mem_wdata;
    logic          w_mem_re;
    logic [AW-1:0] w_mem_raddr;

    rsffa_pkg::t_back_state r_state;
    rsffa_pkg::t_back_state n_state;
    rsffa_pkg::t_job        r_job;
    rsffa_pkg::t_status     r_status;
    logic [AW-1:0]          r_rd_addr;
    logic                   r_rd_more;
    logic                   r_ev_valid;
    logic [AW-1:0]          r_ev_idx;
    logic [7:0]             r_run;
    logic [SW-1:0]          r_start;
    logic [SW-1:0]          r_end;
    logic [AW-1:0]          r_mark_addr;

    logic                   r_out_valid;
    rsffa_pkg::t_status     r_out_status;
    logic signed [16:0]     r_out_rx;
    logic signed [16:0]     r_out_rz;
    logic [9:0]             r_out_idx;
    logic [11:0]            r_out_offset;
    logic [7:0]             r_out_count;
    logic [31:0]            r_out_loc;

    logic [WB-1:0] w_used;
    logic [WB-1:0] w_hit;
    logic          w_hit_any;
    logic [4:0]    w_hit_pos;
    logic          w_any_used;
    logic [4:0]    w_top_pos;
    logic [8:0]    w_run_sum;
    logic [7:0]    w_run_next;
    logic [SW-1:0] w_end;
    logic [SW-1:0] w_start;
    logic [4:0]    w_mark_lo;
    logic [4:0]    w_mark_hi;
    logic [WB-1:0] w_mark_mask;
    logic          w_load_out;
    logic          w_placed;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_bitmap[w_mem_waddr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= r_bitmap[w_mem_raddr];
        end
    end

    // Sectors past the end of the store count as used.
    assign w_used = r_rdata | ((r_ev_idx == LAST_WORD) ? TAIL_MASK : '0);

    // A bit hits when the run of free sectors ending on it reaches the need,
    // counting the free run carried in from the words below.
    for (genvar g = 0; g < WB; g++) begin : g_bit
        localparam logic [7:0] POS = 8'(g + 1);
        logic [5:0]  n_in;
        logic [5:0]  lo;
        logic [32:0] win;
        logic        carry_ok;

        assign n_in     = (r_job.need > POS) ? 6'(g + 1) : 6'(r_job.need);
        assign lo       = 6'(g + 1) - n_in;
        assign win      = ((33'd1 << (g + 1)) - 33'd1) ^ ((33'd1 << lo) - 33'd1);
        assign carry_ok = (r_job.need <= POS) || (r_run >= r_job.need - POS);
        assign w_hit[g] = ((w_used & win[WB-1:0]) == '0) && carry_ok;
    end

    assign w_hit_any  = |w_hit;
    assign w_any_used = |w_used;

    always_comb begin
        w_hit_pos = '0;
        for (int i = WB - 1; i >= 0; i--) begin
            if (w_hit[i]) begin
                w_hit_pos = 5'(i);
            end
        end
    end

    always_comb begin
        w_top_pos = '0;
        for (int i = 0; i < WB; i++) begin
            if (w_used[i]) begin
                w_top_pos = 5'(i);
            end
        end
    end

    assign w_run_sum  = {1'b0, r_run} + 9'(WB);
    assign w_run_next = w_any_used ? 8'(5'd31 - w_top_pos)
                      : (w_run_sum[8] ? 8'(rsffa_pkg::COUNT_LIMIT) : w_run_sum[7:0]);
    assign w_end      = {r_ev_idx, w_hit_pos};
    assign w_start    = w_end - SW'(r_job.need) + SW'(1);

    assign w_mark_lo   = (r_mark_addr == r_start[SW-1:rsffa_pkg::WORD_LSB]) ? r_start[4:0] : '0;
    assign w_mark_hi   = (r_mark_addr == r_end[SW-1:rsffa_pkg::WORD_LSB]) ? r_end[4:0] : 5'd31;
    assign w_mark_mask = WB'(((33'd2 << w_mark_hi) - 33'd1) & ~((33'd1 << w_mark_lo) - 33'd1));

    always_comb begin
        n_state     = r_state;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_rd_addr;
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = r_rd_addr;
        o_job_ready = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            rsffa_pkg::B_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = (r_rd_addr == '0) ? RESERVED_MASK : '0;
                if (r_rd_addr == LAST_WORD) begin
                    n_state = rsffa_pkg::B_IDLE;
                end
            end
            rsffa_pkg::B_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_state = (i_job.status == rsffa_pkg::ST_PLACED) ?
                              rsffa_pkg::B_SCAN : rsffa_pkg::B_DONE;
                end
            end
            rsffa_pkg::B_SCAN: begin
                w_mem_re = r_rd_more;
                if (r_ev_valid) begin
                    if (w_hit_any) begin
                        n_state = rsffa_pkg::B_MARK_RD;
                    end else if (r_ev_idx == LAST_WORD) begin
                        n_state = rsffa_pkg::B_DONE;
                    end
                end
            end
            rsffa_pkg::B_MARK_RD: begin
                w_mem_re    = 1'b1;
                w_mem_raddr = r_mark_addr;
                n_state     = rsffa_pkg::B_MARK_WR;
            end
            rsffa_pkg::B_MARK_WR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_mark_addr;
                w_mem_wdata = r_rdata | w_mark_mask;
                n_state     = (r_mark_addr == r_end[SW-1:rsffa_pkg::WORD_LSB]) ?
                              rsffa_pkg::B_DONE : rsffa_pkg::B_MARK_RD;
            end
            rsffa_pkg::B_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    w_load_out = 1'b1;
                    n_state    = rsffa_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = rsffa_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsffa_pkg::B_CLEAR;
            r_rd_addr   <= '0;
            r_rd_more   <= 1'b0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                rsffa_pkg::B_CLEAR: begin
                    r_rd_addr <= (r_rd_addr == LAST_WORD) ? '0 : r_rd_addr + AW'(1);
                end
                rsffa_pkg::B_IDLE: begin
                    r_rd_addr  <= '0;
                    r_rd_more  <= 1'b1;
                    r_ev_valid <= 1'b0;
                end
                rsffa_pkg::B_SCAN: begin
                    // Reads run one word ahead of the evaluation.
                    r_ev_valid <= r_rd_more;
                    if (r_rd_more) begin
                        if (r_rd_addr == LAST_WORD) begin
                            r_rd_more <= 1'b0;
                        end else begin
                            r_rd_addr <= r_rd_addr + AW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rsffa_pkg::B_IDLE && i_job_valid) begin
            r_job    <= i_job;
            r_status <= i_job.status;
            r_run    <= '0;
        end
        // The word read this cycle is evaluated in the next one.
        if (r_state == rsffa_pkg::B_SCAN && r_rd_more) begin
            r_ev_idx <= r_rd_addr;
        end
        if (r_state == rsffa_pkg::B_SCAN && r_ev_valid) begin
            if (w_hit_any) begin
                r_start     <= w_start;
                r_end       <= w_end;
                r_mark_addr <= w_start[SW-1:rsffa_pkg::WORD_LSB];
            end else begin
                r_run <= w_run_next;
                if (r_ev_idx == LAST_WORD) begin
                    r_status <= rsffa_pkg::ST_FULL;
                end
            end
        end
        if (r_state == rsffa_pkg::B_MARK_WR) begin
            r_mark_addr <= r_mark_addr + AW'(1);
        end
    end

    assign w_placed = (r_status == rsffa_pkg::ST_PLACED);

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_status <= r_status;
            r_out_rx     <= r_job.region_x;
            r_out_rz     <= r_job.region_z;
            r_out_idx    <= r_job.entry_index;
            r_out_offset <= w_placed ? 12'(r_start) : '0;
            r_out_count  <= w_placed ? r_job.need : '0;
            r_out_loc    <= w_placed ? 32'({r_start, r_job.need}) : '0;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.region_x      = r_out_rx;
    assign o_rsp.region_z      = r_out_rz;
    assign o_rsp.entry_index   = r_out_idx;
    assign o_rsp.sector_offset = r_out_offset;
    assign o_rsp.sector_count  = r_out_count;
    assign o_rsp.location_word = r_out_loc;

    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsffa_pkg::B_CLEAR) |-> !o_job_ready)
        else $error("job taken during bitmap clear");

    a_mark_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsffa_pkg::B_MARK_WR) |-> ((r_rdata & w_mark_mask) == '0))
        else $error("allocated run overlaps used sectors");

    a_start_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rsffa_pkg::B_SCAN && r_ev_valid && w_hit_any) |->
        (w_start >= SW'(rsffa_pkg::FIRST_DATA_SECTOR)))
        else $error("run starts inside the header sectors");

    a_zero_unplaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != rsffa_pkg::ST_PLACED) |->
        (r_out_loc == '0 && r_out_count == '0))
        else $error("unplaced result carries a location");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_SECTORS = 4096;

    typedef struct {
        logic signed [21:0] cx;
        logic signed [21:0] cz;
        logic [23:0]        nbytes;
    } t_chunk_req;

    typedef struct {
        rsffa_pkg::t_status status;
        logic signed [16:0] region_x;
        logic signed [16:0] region_z;
        logic [9:0]         entry_index;
        logic [11:0]        sector_offset;
        logic [7:0]         sector_count;
        logic [31:0]        location_word;
    } t_slot_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rsffa_req_if req_bus ();
    rsffa_rsp_if rsp_bus ();

    region_sector_first_fit_allocator_unit #(
        .MAX_SECTORS(MAX_SECTORS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always #5 i_clk = ~i_clk;

    t_chunk_req  pending_chunks[$];
    t_slot_reply predicted_slots[$];
    t_chunk_req  next_chunk;
    t_slot_reply want;
    bit [MAX_SECTORS-1:0] sector_map;
    int req_cnt = 0;
    int err_cnt = 0;
    int status_seen[4];
    int hold_cycles = 0;
    bit hold_armed = 1'b1;

    task automatic report_mismatch(input string what, input longint got, input longint exp);
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, exp);
        err_cnt++;
    endtask

    // Mirrors one allocation: classifies the payload, runs the first-fit scan on
    // the shadow bitmap and marks the run when it is placed.
    function automatic t_slot_reply place_chunk(logic signed [21:0] cx,
                                                logic signed [21:0] cz,
                                                logic [23:0] nbytes);
        t_slot_reply rep;
        int need;
        int run;
        int start;
        bit found;
        rep.region_x      = cx[21:5];
        rep.region_z      = cz[21:5];
        rep.entry_index   = {cz[4:0], cx[4:0]};
        rep.sector_offset = '0;
        rep.sector_count  = '0;
        rep.location_word = '0;
        need  = (int'(nbytes) + rsffa_pkg::SECTOR_ROUND) / rsffa_pkg::SECTOR_BYTES;
        run   = 0;
        start = 0;
        found = 1'b0;
        if (nbytes == 0) begin
            rep.status = rsffa_pkg::ST_EMPTY;
        end else if (need > rsffa_pkg::COUNT_LIMIT) begin
            rep.status = rsffa_pkg::ST_OVER;
        end else begin
            for (int i = rsffa_pkg::FIRST_DATA_SECTOR; i < MAX_SECTORS && !found; i++) begin
                if (!sector_map[i]) begin
                    run++;
                    if (run == need) begin
                        start = i + 1 - need;
                        found = 1'b1;
                    end
                end else begin
                    run = 0;
                end
            end
            if (!found) begin
                rep.status = rsffa_pkg::ST_FULL;
            end else begin
                for (int k = 0; k < need; k++)
                    sector_map[start + k] = 1'b1;
                rep.status        = rsffa_pkg::ST_PLACED;
                rep.sector_offset = start[11:0];
                rep.sector_count  = need[7:0];
                rep.location_word = (32'(start) << 8) | 32'(need);
            end
        end
        return rep;
    endfunction

    function automatic int longest_free_run();
        int run;
        int best;
        run  = 0;
        best = 0;
        for (int i = rsffa_pkg::FIRST_DATA_SECTOR; i < MAX_SECTORS; i++) begin
            run  = sector_map[i] ? 0 : run + 1;
            best = (run > best) ? run : best;
        end
        return best;
    endfunction

    // Any payload length that rounds up to exactly n sectors with its header.
    function automatic logic [23:0] bytes_for_sectors(int n);
        int lo;
        lo = (n == 1) ? 1 : (n - 1) * rsffa_pkg::SECTOR_BYTES - rsffa_pkg::HEADER_BYTES + 1;
        return 24'($urandom_range(n * rsffa_pkg::SECTOR_BYTES - rsffa_pkg::HEADER_BYTES, lo));
    endfunction

    function automatic logic signed [21:0] random_coord();
        int v;
        if ($urandom_range(0, 3) == 0) begin
            v = $urandom_range(0, 255) - 128;
            return v[21:0];
        end
        return 22'($urandom());
    endfunction

    function automatic logic [23:0] random_payload();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 10)
            return 24'($urandom_range(24'hFFFFFF, rsffa_pkg::COUNT_LIMIT * rsffa_pkg::SECTOR_BYTES
                                                  - rsffa_pkg::HEADER_BYTES + 1));
        if (roll < 75)
            return bytes_for_sectors($urandom_range(1, 3));
        if (roll < 99)
            return bytes_for_sectors($urandom_range(4, 24));
        return bytes_for_sectors($urandom_range(25, rsffa_pkg::COUNT_LIMIT));
    endfunction

    task automatic queue_chunk(logic signed [21:0] cx, logic signed [21:0] cz,
                               logic [23:0] nbytes);
        t_chunk_req r;
        r.cx     = cx;
        r.cz     = cz;
        r.nbytes = nbytes;
        pending_chunks = {pending_chunks, r};
    endtask

    task automatic wait_idle();
        while (pending_chunks.size() != 0 || req_bus.valid || predicted_slots.size() != 0)
            @(negedge i_clk);
    endtask

    // Idle pattern follows progress: light sender gaps with a busy receiver,
    // then the reverse, then full rate on both sides.
    function automatic bit sender_pause();
        if (req_cnt < 170)
            return $urandom_range(0, 99) < 9;
        if (req_cnt < 340)
            return $urandom_range(0, 99) < 64;
        return 1'b0;
    endfunction

    function automatic bit receiver_pause();
        if (req_cnt < 170)
            return $urandom_range(0, 99) < 64;
        if (req_cnt < 340)
            return $urandom_range(0, 99) < 9;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else if (!req_bus.valid || req_bus.ready) begin
            if (pending_chunks.size() != 0 && !sender_pause()) begin
                next_chunk = pending_chunks.pop_front();
                req_bus.valid            <= 1'b1;
                req_bus.chunk_x          <= next_chunk.cx;
                req_bus.chunk_z          <= next_chunk.cz;
                req_bus.compressed_bytes <= next_chunk.nbytes;
            end else begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_cnt <= 0;
        end else if (req_bus.valid && req_bus.ready) begin
            predicted_slots = {predicted_slots,
                               place_chunk(req_bus.chunk_x, req_bus.chunk_z,
                                           req_bus.compressed_bytes)};
            req_cnt <= req_cnt + 1;
        end
    end

    // One long receiver stall while requests keep coming, so the input queue backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cycles <= 0;
            hold_armed  <= 1'b1;
        end else if (hold_armed && req_cnt == 100) begin
            hold_cycles <= 400;
            hold_armed  <= 1'b0;
        end else if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= (hold_cycles == 0) && !receiver_pause();
            if (rsp_bus.valid && rsp_bus.ready) begin
                status_seen[rsp_bus.status]++;
                if (predicted_slots.size() == 0) begin
                    report_mismatch("unexpected reply status", int'(rsp_bus.status), -1);
                end else begin
                    want = predicted_slots.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", int'(rsp_bus.status), int'(want.status));
                    if (rsp_bus.region_x !== want.region_x)
                        report_mismatch("region_x", rsp_bus.region_x, want.region_x);
                    if (rsp_bus.region_z !== want.region_z)
                        report_mismatch("region_z", rsp_bus.region_z, want.region_z);
                    if (rsp_bus.entry_index !== want.entry_index)
                        report_mismatch("entry_index", rsp_bus.entry_index, want.entry_index);
                    if (rsp_bus.sector_offset !== want.sector_offset)
                        report_mismatch("sector_offset", rsp_bus.sector_offset,
                                        want.sector_offset);
                    if (rsp_bus.sector_count !== want.sector_count)
                        report_mismatch("sector_count", rsp_bus.sector_count,
                                        want.sector_count);
                    if (rsp_bus.location_word !== want.location_word)
                        report_mismatch("location_word", rsp_bus.location_word,
                                        want.location_word);
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int longest;
        bit store_open;
        i_rst_n                  = 1'b0;
        req_bus.valid            = 1'b0;
        req_bus.chunk_x          = '0;
        req_bus.chunk_z          = '0;
        req_bus.compressed_bytes = '0;
        rsp_bus.ready            = 1'b0;
        sector_map               = '0;
        sector_map[0]            = 1'b1;
        sector_map[1]            = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sector rounding edges, coordinate extremes, empty and oversized payloads.
        queue_chunk(22'sd0, 22'sd0, 24'd1);
        queue_chunk(-22'sd1, -22'sd1, 24'd4091);
        queue_chunk(22'sd2097151, -22'sd2097152, 24'd4092);
        queue_chunk(-22'sd2097152, 22'sd2097151, 24'd0);
        queue_chunk(22'sd31, 22'sd32, 24'd1044475);
        queue_chunk(-22'sd32, -22'sd33, 24'd1044476);
        queue_chunk(-22'sd33, 22'sd31, 24'hFFFFFF);
        queue_chunk(22'sd32, -22'sd31, 24'd8187);
        queue_chunk(22'sd1, 22'sd1023, 24'd8188);
        queue_chunk(22'sd0, 22'sd0, 24'd0);
        queue_chunk(-22'sd2097152, -22'sd2097152, 24'h800000);
        queue_chunk(22'sd2097151, 22'sd2097151, 24'd12283);

        for (int n = 0; n < 500; n++)
            queue_chunk(random_coord(), random_coord(), random_payload());

        // Fill the store: probe one sector past the longest hole, then fill it.
        store_open = 1'b1;
        while (store_open) begin
            wait_idle();
            longest = longest_free_run();
            if (longest == 0) begin
                store_open = 1'b0;
            end else begin
                if (longest < rsffa_pkg::COUNT_LIMIT)
                    queue_chunk(random_coord(), random_coord(), bytes_for_sectors(longest + 1));
                queue_chunk(random_coord(), random_coord(),
                            bytes_for_sectors(longest < rsffa_pkg::COUNT_LIMIT ?
                                              longest : rsffa_pkg::COUNT_LIMIT));
            end
        end

        // Requests against a full store, plus the skip cases once more.
        for (int n = 0; n < 12; n++)
            queue_chunk(random_coord(), random_coord(), bytes_for_sectors($urandom_range(1, 4)));
        queue_chunk(random_coord(), random_coord(), 24'd0);
        queue_chunk(random_coord(), random_coord(), 24'hFFFFFF);

        wait_idle();
        repeat (200) @(negedge i_clk);
        if (predicted_slots.size() != 0)
            report_mismatch("replies still outstanding", 0, predicted_slots.size());

        $display("Sent %0d chunk requests under three idle patterns and one long output stall.",
                 req_cnt);
        $display("Replies: %0d placed, %0d empty, %0d oversized, %0d store full; %0d sectors used.",
                 status_seen[rsffa_pkg::ST_PLACED], status_seen[rsffa_pkg::ST_EMPTY],
                 status_seen[rsffa_pkg::ST_OVER], status_seen[rsffa_pkg::ST_FULL],
                 $countones(sector_map));
        if (err_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
src/rsffa_pkg.sv
src/rsffa_if.sv
src/rsffa_front.sv
src/rsffa_back.sv
src/region_sector_first_fit_allocator_unit.sv
verif/testbench.sv
